### rtl/core/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared constants, codes and the reset coefficient table of the band-pass
// biquad cascade.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int DIGIT_BITS  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int STAGE_BITS  = 3;
  localparam int SEL_BITS    = 2;
  localparam int VALUE_BITS  = 32;
  localparam int TAPS        = 4;
  localparam int BAND_SECS   = 6;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // coefficient lanes, also the order of the MAC terms
  localparam logic [SEL_BITS-1:0] SEL_B0 = 2'd0;
  localparam logic [SEL_BITS-1:0] SEL_B2 = 2'd1;
  localparam logic [SEL_BITS-1:0] SEL_A1 = 2'd2;
  localparam logic [SEL_BITS-1:0] SEL_A2 = 2'd3;

  // history slots
  localparam logic [1:0] SLOT_X1 = 2'd0;
  localparam logic [1:0] SLOT_X2 = 2'd1;
  localparam logic [1:0] SLOT_Y1 = 2'd2;
  localparam logic [1:0] SLOT_Y2 = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = 16'sh8000;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic signed [31:0] BAND_TABLE [BAND_SECS][TAPS] = '{
    '{32'sd26736171, -32'sd26736171, -32'sd2084132880, 32'sd1020376855},
    '{32'sd33822867, -32'sd33822867, -32'sd2077153559, 32'sd1010498431},
    '{32'sd21367462, -32'sd21367462, -32'sd2134383998, 32'sd1063541277},
    '{32'sd24373939, -32'sd24373939, -32'sd2114412400, 32'sd1052696484},
    '{32'sd40587441, -32'sd40587441, -32'sd2113123910, 32'sd1042710685},
    '{32'sd37688338, -32'sd37688338, -32'sd2091434325, 32'sd1022309591}
  };

  typedef struct packed {
    logic rd_en;
    logic hist_we;
    logic coef_we;
  } cbb_mem_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } cbb_mac_ctrl_t;

  // reset coefficient in Q2.30; sections past the table pass through
  function automatic logic signed [31:0] band_coef(input logic [3:0] sec,
                                                   input logic [SEL_BITS-1:0] lane);
    logic signed [31:0] v;
    if (sec < 4'(BAND_SECS)) begin
      v = BAND_TABLE[sec[2:0]][lane];
    end else if (lane == SEL_B0) begin
      v = ONE_Q30;
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

### rtl/core/cbb_if.sv
// ----------------------------------------------------------------------------
// cbb_if
// Valid/ready channels of the biquad cascade: input words and result words.
// ----------------------------------------------------------------------------
interface cbb_in_if import cbb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [STAGE_BITS-1:0]  stage;
  logic        [SEL_BITS-1:0]    coef_sel;
  logic signed [VALUE_BITS-1:0]  coef_value;

  modport source (output valid, kind, sample, stage, coef_sel, coef_value, input ready);
  modport sink   (input valid, kind, sample, stage, coef_sel, coef_value, output ready);
endinterface

interface cbb_out_if import cbb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface

### rtl/core/cbb_store.sv
// ----------------------------------------------------------------------------
// cbb_store
// Coefficient and history memories, one row per section, with the reset
// fill sweep that loads the band-pass table and clears the history.
// ----------------------------------------------------------------------------
module cbb_store import cbb_pkg::*; #(
  parameter int NUM_SECTIONS = 6,
  parameter int COEF_BITS    = 32,
  parameter int SIGNAL_BITS  = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbb_mem_ctrl_t                          ctrl_i,
  input  logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] sec_addr_i,
  input  logic [TAPS-1:0][SIGNAL_BITS-1:0]       hist_wdata_i,
  input  logic [((NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1)-1:0] coef_addr_i,
  input  logic [SEL_BITS-1:0]                    coef_lane_i,
  input  logic [COEF_BITS-1:0]                   coef_data_i,
  output logic [TAPS-1:0][COEF_BITS-1:0]         coef_rd_o,
  output logic [TAPS-1:0][SIGNAL_BITS-1:0]       hist_rd_o,
  output logic                                   init_busy_o
);

  localparam int SEC_W     = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int RST_SHIFT = 32 - COEF_BITS;
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);
  localparam logic signed [32:0] RST_HALF = 33'((1 << RST_SHIFT) >> 1);

  logic [TAPS-1:0][COEF_BITS-1:0]   coef_mem [NUM_SECTIONS];
  logic [TAPS-1:0][SIGNAL_BITS-1:0] hist_mem [NUM_SECTIONS];

  logic [TAPS-1:0][COEF_BITS-1:0]   coef_rd_q;
  logic [TAPS-1:0][SIGNAL_BITS-1:0] hist_rd_q;
  logic [TAPS-1:0][COEF_BITS-1:0]   rst_row;
  logic                             init_busy_q;
  logic [SEC_W-1:0]                 init_cnt_q;

  always_comb begin
    logic signed [32:0] raw;
    raw = '0;
    for (int j = 0; j < TAPS; j++) begin
      raw        = 33'(band_coef(4'(init_cnt_q), SEL_BITS'(j)));
      rst_row[j] = COEF_BITS'((raw + RST_HALF) >>> RST_SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_cnt_q  <= '0;
    end else if (init_busy_q) begin
      if (init_cnt_q == LAST_SEC) begin
        init_busy_q <= 1'b0;
      end else begin
        init_cnt_q <= init_cnt_q + SEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_busy_q) begin
      coef_mem[init_cnt_q] <= rst_row;
      hist_mem[init_cnt_q] <= '0;
    end else begin
      if (ctrl_i.coef_we) begin
        coef_mem[coef_addr_i][coef_lane_i] <= coef_data_i;
      end
      if (ctrl_i.hist_we) begin
        hist_mem[sec_addr_i] <= hist_wdata_i;
      end
      if (ctrl_i.rd_en) begin
        coef_rd_q <= coef_mem[sec_addr_i];
        hist_rd_q <= hist_mem[sec_addr_i];
      end
    end
  end

  assign coef_rd_o   = coef_rd_q;
  assign hist_rd_o   = hist_rd_q;
  assign init_busy_o = init_busy_q;

endmodule

### rtl/core/cbb_mac.sv
// ----------------------------------------------------------------------------
// cbb_mac
// Digit-serial multiply-accumulate of one section: coefficients shift out
// one 8-bit digit per cycle while step is high, MSB digit first, over the
// four terms; the sum is rounded half up and saturated to the signal width.
// ----------------------------------------------------------------------------
module cbb_mac import cbb_pkg::*; #(
  parameter int COEF_BITS   = 32,
  parameter int SIGNAL_BITS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cbb_mac_ctrl_t                    ctrl_i,
  input  logic [TAPS-1:0][COEF_BITS-1:0]   coef_i,
  input  logic [TAPS-1:0][SIGNAL_BITS-1:0] sig_i,
  output logic                             last_o,
  output logic signed [SIGNAL_BITS-1:0]    y_o
);

  localparam int NDIG  = (COEF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CW    = NDIG * DIGIT_BITS;
  localparam int DIG_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int ACC_W = SIGNAL_BITS + CW + 2;
  localparam int PP_W  = SIGNAL_BITS + DIGIT_BITS + 1;
  localparam int FRAC  = COEF_BITS - 2;
  localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NDIG - 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [SIGNAL_BITS-1:0] SMAX = {1'b0, {(SIGNAL_BITS-1){1'b1}}};
  localparam logic signed [SIGNAL_BITS-1:0] SMIN = {1'b1, {(SIGNAL_BITS-1){1'b0}}};

  logic [TAPS-1:0][CW-1:0]  coef_sh_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [SEL_BITS-1:0]      term_q;
  logic [DIG_W-1:0]         dig_q;

  logic [DIGIT_BITS-1:0]        digit;
  logic signed [DIGIT_BITS:0]   dsig;
  logic signed [PP_W-1:0]       pp;
  logic signed [ACC_W-1:0]      base;
  logic signed [ACC_W-1:0]      rnd;
  logic signed [ACC_W-1:0]      yf;
  logic                         ovf_pos, ovf_neg;

  always_comb begin
    digit = coef_sh_q[term_q][CW-1 -: DIGIT_BITS];
    dsig  = (dig_q == '0) ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
    pp    = $signed(sig_i[term_q]) * dsig;
    base  = (term_q == SEL_B0) ? (acc_q <<< DIGIT_BITS) : acc_q;
    if (term_q == SEL_A1 || term_q == SEL_A2) begin
      acc_d = base - ACC_W'(pp);
    end else begin
      acc_d = base + ACC_W'(pp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= SEL_B0;
      dig_q  <= '0;
    end else if (ctrl_i.load) begin
      term_q <= SEL_B0;
      dig_q  <= '0;
    end else if (ctrl_i.step) begin
      term_q <= term_q + SEL_BITS'(1);
      if (term_q == SEL_A2) begin
        dig_q <= dig_q + DIG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= '0;
      for (int k = 0; k < TAPS; k++) begin
        coef_sh_q[k] <= CW'($signed(coef_i[k]));
      end
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
      if (term_q == SEL_A2) begin
        for (int k = 0; k < TAPS; k++) begin
          coef_sh_q[k] <= coef_sh_q[k] << DIGIT_BITS;
        end
      end
    end
  end

  assign last_o = (term_q == SEL_A2) && (dig_q == LAST_DIG);

  always_comb begin
    rnd     = acc_q + HALF;
    yf      = rnd >>> FRAC;
    ovf_pos = !yf[ACC_W-1] && (|yf[ACC_W-1:SIGNAL_BITS-1]);
    ovf_neg = yf[ACC_W-1] && !(&yf[ACC_W-1:SIGNAL_BITS-1]);
    if (ovf_pos) begin
      y_o = SMAX;
    end else if (ovf_neg) begin
      y_o = SMIN;
    end else begin
      y_o = yf[SIGNAL_BITS-1:0];
    end
  end

endmodule

### rtl/core/cascaded_biquad_bandpass_top.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass_top
// Cascade of NUM_SECTIONS band-pass biquads (direct form I, b1 = 0).
// in_i takes words of two kinds: an audio sample (kind 0) or a write of one
// Q2.30 coefficient (kind 1), which yields no word.
// out_o carries one filtered 16-bit sample per audio word.
// A sample runs per section: one memory read, one load, 4*NDIG digit steps
// of the shared 8-bit digit MAC (NDIG = COEF_BITS/8 rounded up), one write
// back; after the last section the result enters the output register, and
// the next word is taken in the cycle after that.
// After reset a fill sweep over all NUM_SECTIONS sections loads the coefficient
// table and clears the history; in_i.ready stays low meanwhile.
// A stalled receiver holds the result in the output register; one more
// sample may finish and then waits until that register frees.
// ----------------------------------------------------------------------------
module cascaded_biquad_bandpass_top import cbb_pkg::*; #(
  parameter int NUM_SECTIONS = 6,
  parameter int COEF_BITS    = 32,
  parameter int SIGNAL_BITS  = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbb_in_if.sink    in_i,
  cbb_out_if.source out_o
);

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int QW    = SIGNAL_BITS - SAMPLE_BITS;
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_WRAP = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [SEC_W-1:0]              sec_q, sec_d;
  logic signed [SIGNAL_BITS-1:0] x_q, x_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] filtered_q;

  cbb_mem_ctrl_t                    mem_ctrl;
  cbb_mac_ctrl_t                    mac_ctrl;
  logic [TAPS-1:0][COEF_BITS-1:0]   coef_rd;
  logic [TAPS-1:0][SIGNAL_BITS-1:0] hist_rd;
  logic [TAPS-1:0][SIGNAL_BITS-1:0] hist_wdata;
  logic [TAPS-1:0][SIGNAL_BITS-1:0] sig;
  logic                             init_busy;
  logic                             mac_last;
  logic signed [SIGNAL_BITS-1:0]    mac_y;
  logic                             in_ready;
  logic                             in_take;
  logic                             stage_ok;
  logic                             out_load;

  logic signed [QW-1:0]          quot;
  logic [QW-SAMPLE_BITS:0]       quot_hi;
  logic signed [SAMPLE_BITS-1:0] filtered_d;

  cbb_store #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .COEF_BITS    (COEF_BITS),
    .SIGNAL_BITS  (SIGNAL_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mem_ctrl),
    .sec_addr_i   (sec_q),
    .hist_wdata_i (hist_wdata),
    .coef_addr_i  (SEC_W'(in_i.stage)),
    .coef_lane_i  (in_i.coef_sel),
    .coef_data_i  (in_i.coef_value[COEF_BITS-1:0]),
    .coef_rd_o    (coef_rd),
    .hist_rd_o    (hist_rd),
    .init_busy_o  (init_busy)
  );

  assign sig[SEL_B0] = x_q;
  assign sig[SEL_B2] = hist_rd[SLOT_X2];
  assign sig[SEL_A1] = hist_rd[SLOT_Y1];
  assign sig[SEL_A2] = hist_rd[SLOT_Y2];

  cbb_mac #(
    .COEF_BITS   (COEF_BITS),
    .SIGNAL_BITS (SIGNAL_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd),
    .sig_i  (sig),
    .last_o (mac_last),
    .y_o    (mac_y)
  );

  assign hist_wdata[SLOT_X1] = x_q;
  assign hist_wdata[SLOT_X2] = hist_rd[SLOT_X1];
  assign hist_wdata[SLOT_Y1] = mac_y;
  assign hist_wdata[SLOT_Y2] = hist_rd[SLOT_Y1];

  assign in_ready = (state_q == ST_IDLE) && !init_busy;
  assign in_take  = in_i.valid && in_ready;
  assign stage_ok = 32'(in_i.stage) < 32'(NUM_SECTIONS);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d          = state_q;
    sec_d            = sec_q;
    x_d              = x_q;
    mem_ctrl         = '0;
    mac_ctrl         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (in_i.kind == KIND_COEF) begin
            mem_ctrl.coef_we = stage_ok;
          end else begin
            x_d     = SIGNAL_BITS'($signed(in_i.sample)) <<< SAMPLE_BITS;
            sec_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_ctrl.rd_en = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        mac_ctrl.load = 1'b1;
        state_d       = ST_MAC;
      end
      ST_MAC: begin
        mac_ctrl.step = 1'b1;
        if (mac_last) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        mem_ctrl.hist_we = 1'b1;
        x_d              = mac_y;
        if (sec_q == LAST_SEC) begin
          state_d = ST_OUT;
        end else begin
          sec_d   = sec_q + SEC_W'(1);
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // truncate toward zero, then saturate to 16 bits
  always_comb begin
    quot    = $signed(x_q[SIGNAL_BITS-1:SAMPLE_BITS])
              + QW'(x_q[SIGNAL_BITS-1] && (|x_q[SAMPLE_BITS-1:0]));
    quot_hi = quot[QW-1:SAMPLE_BITS-1];
    if (!quot[QW-1] && (|quot_hi)) begin
      filtered_d = OUT_MAX;
    end else if (quot[QW-1] && !(&quot_hi)) begin
      filtered_d = OUT_MIN;
    end else begin
      filtered_d = quot[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (out_load) begin
      filtered_q <= filtered_d;
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = filtered_q;

`ifndef SYNTH
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result word raised outside the output state");

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= LAST_SEC)
    else $error("section index past the last section");

  a_no_take_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !in_i.ready)
    else $error("input taken during the memory fill sweep");

  a_wrap_after_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRAP) |-> $past(state_q == ST_MAC && mac_last))
    else $error("write back without a finished MAC pass");
`endif

endmodule

### tb/tb_cascaded_biquad_bandpass_top.sv
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_bandpass_top
// Self-checking bench for the six-section band-pass biquad cascade. Words go
// in over the valid/ready input channel: audio samples, and coefficient
// writes that include out-of-range sections. A bit-exact fixed-point model
// in the scoreboard predicts every filtered sample. Both channel sides idle
// at random, and the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cascaded_biquad_bandpass_top import cbb_pkg::*; ();

  localparam int NUM_SECTIONS = 6;
  localparam int COEF_BITS    = 32;
  localparam int SIGNAL_BITS  = 40;
  localparam int COEF_FRAC    = COEF_BITS - 2;
  localparam int ACC_BITS     = COEF_BITS + SIGNAL_BITS + 4;
  localparam int ITEM_TARGET  = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;

  typedef logic signed [SIGNAL_BITS-1:0] signal_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [SAMPLE_BITS-1:0] pcm_t;

  typedef struct packed {
    logic                         kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [STAGE_BITS-1:0]  stage;
    logic        [SEL_BITS-1:0]    coef_sel;
    logic signed [VALUE_BITS-1:0]  coef_value;
  } in_word_t;

  class cascade_scoreboard;
    coef_t   coef [NUM_SECTIONS][TAPS];
    signal_t x1 [NUM_SECTIONS];
    signal_t x2 [NUM_SECTIONS];
    signal_t y1 [NUM_SECTIONS];
    signal_t y2 [NUM_SECTIONS];
    pcm_t    filtered_q [$];
    int      errors;
    int      checked;
    int      samples;
    int      writes;

    function new();
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        for (int j = 0; j < TAPS; j++) begin
          if (s < BAND_SECS) coef[s][j] = BAND_TABLE[s][j];
          else coef[s][j] = (j == int'(SEL_B0)) ? ONE_Q30 : '0;
        end
        x1[s] = '0;
        x2[s] = '0;
        y1[s] = '0;
        y2[s] = '0;
      end
      errors  = 0;
      checked = 0;
      samples = 0;
      writes  = 0;
    endfunction

    function signal_t run_section(int s, signal_t x);
      acc_t    acc, half, top, bot;
      acc_t    cb0, cb2, ca1, ca2, sx, sx2, sy1, sy2;
      signal_t y;
      cb0  = acc_t'(coef[s][SEL_B0]);
      cb2  = acc_t'(coef[s][SEL_B2]);
      ca1  = acc_t'(coef[s][SEL_A1]);
      ca2  = acc_t'(coef[s][SEL_A2]);
      sx   = acc_t'(x);
      sx2  = acc_t'(x2[s]);
      sy1  = acc_t'(y1[s]);
      sy2  = acc_t'(y2[s]);
      half = acc_t'(1) <<< (COEF_FRAC - 1);
      top  = (acc_t'(1) <<< (SIGNAL_BITS - 1)) - acc_t'(1);
      bot  = -top - acc_t'(1);
      acc  = cb0 * sx + cb2 * sx2 - ca1 * sy1 - ca2 * sy2;
      acc  = (acc + half) >>> COEF_FRAC;
      if (acc > top) acc = top;
      else if (acc < bot) acc = bot;
      y = signal_t'(acc);
      x2[s] = x1[s];
      x1[s] = x;
      y2[s] = y1[s];
      y1[s] = y;
      return y;
    endfunction

    function pcm_t filter_sample(pcm_t smp);
      signal_t v, q;
      v = signal_t'(smp);
      v = v <<< 16;
      for (int s = 0; s < NUM_SECTIONS; s++) v = run_section(s, v);
      q = v / signal_t'(65536);
      if (q > signal_t'(OUT_MAX)) q = signal_t'(OUT_MAX);
      else if (q < signal_t'(OUT_MIN)) q = signal_t'(OUT_MIN);
      return q[SAMPLE_BITS-1:0];
    endfunction

    function void note_word(in_word_t w);
      if (w.kind == KIND_COEF) begin
        writes++;
        if (w.stage < NUM_SECTIONS) coef[w.stage][w.coef_sel] = w.coef_value;
      end else begin
        samples++;
        filtered_q.push_back(filter_sample(w.sample));
      end
    endfunction

    function void check_filtered(pcm_t got);
      pcm_t want;
      checked++;
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word %0d with none expected: got %0d", checked, got);
        return;
      end
      want = filtered_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("result word %0d: expected %0d, got %0d", checked, want, got);
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic no_idle = 1'b0;
  int   sent = 0;

  cascade_scoreboard sb = new();

  cbb_in_if  in_if ();
  cbb_out_if out_if ();

  cascaded_biquad_bandpass_top #(
    .NUM_SECTIONS(NUM_SECTIONS),
    .COEF_BITS   (COEF_BITS),
    .SIGNAL_BITS (SIGNAL_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_cascaded_biquad_bandpass_top: done, errors");
    $finish;
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= w.kind;
    in_if.sample     <= w.sample;
    in_if.stage      <= w.stage;
    in_if.coef_sel   <= w.coef_sel;
    in_if.coef_value <= w.coef_value;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(w);
    sent++;
  endtask

  task automatic send_sample(pcm_t smp);
    in_word_t w;
    w            = '0;
    w.kind       = KIND_SAMPLE;
    w.sample     = smp;
    w.stage      = STAGE_BITS'($urandom);
    w.coef_sel   = SEL_BITS'($urandom);
    w.coef_value = $urandom;
    send_word(w);
  endtask

  task automatic send_coef(int st, int sel, coef_t value);
    in_word_t w;
    w            = '0;
    w.kind       = KIND_COEF;
    w.sample     = SAMPLE_BITS'($urandom);
    w.stage      = STAGE_BITS'(st);
    w.coef_sel   = SEL_BITS'(sel);
    w.coef_value = value;
    send_word(w);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, plus two long hold-offs to back up the input
  initial begin : result_side
    int stall;
    int taken;
    taken = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken == 120 || taken == 400) stall = HOLD_CYCLES;
      else stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_filtered(out_if.filtered);
      taken++;
    end
  end

  initial begin : stimulus
    int    seg, n, period, style, cnt, st, sel;
    logic  dirty;
    pcm_t  amp, smp;
    coef_t gain, value;
    rst_ni = 1'b0;
    dirty  = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KIND_SAMPLE;
    in_if.sample     <= '0;
    in_if.stage      <= '0;
    in_if.coef_sel   <= SEL_B0;
    in_if.coef_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(OUT_MAX);
    send_sample(OUT_MIN);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    // sections past the cascade: ignored
    send_coef(7, SEL_A2, 32'sh8000_0000);
    send_coef(6, SEL_B0, 32'sh7fff_ffff);
    send_sample(16'sd12345);
    // unstable last section drives the signal into saturation
    send_coef(5, SEL_B0, 32'sh7fff_ffff);
    send_coef(5, SEL_B2, 32'sh8000_0000);
    send_coef(5, SEL_A1, 32'sh8000_0000);
    send_coef(5, SEL_A2, 32'sh7fff_ffff);
    send_sample(OUT_MAX);
    send_sample(OUT_MIN);
    send_sample(OUT_MAX);
    for (int j = 0; j < TAPS; j++) send_coef(5, j, BAND_TABLE[5][j]);
    send_sample(-16'sd20000);
    drain_results();

    while (sent < ITEM_TARGET) begin
      seg     = dirty ? 1 : $urandom_range(0, 3);
      no_idle = ($urandom_range(0, 3) == 0);
      dirty   = 1'b0;
      if (seg == 0) begin
        if ($urandom_range(0, 1) == 1) drain_results();
        for (int s = 0; s < BAND_SECS; s++)
          for (int j = 0; j < TAPS; j++) send_coef(s, j, BAND_TABLE[s][j]);
      end else if (seg == 1) begin
        // plain gain path; also flushes any saturated history
        if ($urandom_range(0, 1) == 1) gain = $urandom;
        else gain = ONE_Q30 + $urandom_range(0, 4095) - 2048;
        for (int s = 0; s < NUM_SECTIONS; s++)
          for (int j = 0; j < TAPS; j++)
            send_coef(s, j, (j != int'(SEL_B0)) ? coef_t'(0) : (s == 0) ? gain : ONE_Q30);
      end else if (seg == 2) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) begin
          st  = $urandom_range(0, 7);
          sel = $urandom_range(0, 3);
          if ($urandom_range(0, 3) == 0) begin
            value = $urandom;
            if (st < NUM_SECTIONS) dirty = 1'b1;
          end else begin
            value = BAND_TABLE[st % BAND_SECS][sel] + $urandom_range(0, 131071) - 65536;
          end
          send_coef(st, sel, value);
        end
      end
      style  = $urandom_range(0, 3);
      period = $urandom_range(4, 40);
      amp    = pcm_t'($urandom);
      n      = $urandom_range(10, 40);
      for (int k = 0; k < n; k++) begin
        case (style)
          0:       smp = pcm_t'($urandom);
          1:       smp = pcm_t'($urandom_range(0, 512) - 256);
          2:       smp = ((k / (period / 2)) % 2 == 1) ? amp : -amp;
          default: begin
            case ($urandom_range(0, 2))
              0:       smp = OUT_MAX;
              1:       smp = OUT_MIN;
              default: smp = '0;
            endcase
          end
        endcase
        if ($urandom_range(0, 7) == 0) smp = pcm_t'($urandom);
        send_sample(smp);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected result words never arrived", sb.pending());
    end
    $display("covered %0d audio words and %0d coefficient writes in %0d input words",
             sb.samples, sb.writes, sent);
    $display("checked %0d result words, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_cascaded_biquad_bandpass_top: done, clean");
    end else begin
      $display("tb_cascaded_biquad_bandpass_top: done, errors");
    end
    $finish;
  end

endmodule
